[rtl/ccs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the charger contactor sequencer
// Phase codes, channel payloads and the sequencer state record.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int DELAY_W = 16;
    localparam logic [DELAY_W-1:0] SETTLE_RESET = 16'd1000;

    typedef enum logic [1:0] {
        PH_STOP = 2'd0,
        PH_PRE  = 2'd1,
        PH_BRK  = 2'd2,
        PH_WORK = 2'd3
    } t_phase;

    typedef struct packed {
        logic ready_req;
        logic start_req;
        logic warn_active;
        logic error_active;
        logic precharge_done;
        logic tick;
    } t_in_item;

    typedef struct packed {
        logic [1:0] phase;
        logic       working;
        logic       stop_entry;
        logic       fan_on;
        logic       battery_breaker_on;
        logic       precharge_restart;
        logic       fault_clear;
        logic       current_update;
    } t_out_item;

    typedef struct packed {
        logic [DELAY_W-1:0] settle_delay;
    } t_cfg_item;

    typedef struct packed {
        t_phase phase;
        logic   entry_pending;
        logic   fan_level;
        logic   breaker_level;
    } t_seq_state;

endpackage

[rtl/ccs_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_stream_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface ccs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ccs_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_eval: one sequencer evaluation
// Resolves the phase chain stop -> precharge -> breaker -> work in one pass.
// ----------------------------------------------------------------------------
module ccs_eval #(
    parameter int COUNT_BITS = 16
) (
    input  ccs_pkg::t_seq_state                i_state,
    input  logic [COUNT_BITS-1:0]              i_count,
    input  ccs_pkg::t_in_item                  i_item,
    input  logic [ccs_pkg::DELAY_W-1:0]        i_settle_delay,
    output ccs_pkg::t_seq_state                o_state,
    output logic [COUNT_BITS-1:0]              o_count,
    output ccs_pkg::t_out_item                 o_result
);

    localparam int CMP_W = (COUNT_BITS > ccs_pkg::DELAY_W) ? COUNT_BITS : ccs_pkg::DELAY_W;

    ccs_pkg::t_phase       p;
    logic                  e;
    logic                  fan;
    logic                  brk;
    logic [COUNT_BITS-1:0] cnt;
    logic                  stop_p;
    logic                  pre_p;
    logic                  clr_p;
    logic                  cur_p;
    logic                  advance_ok;

    always_comb begin
        p          = i_state.phase;
        e          = i_state.entry_pending;
        fan        = i_state.fan_level;
        brk        = i_state.breaker_level;
        cnt        = i_count;
        stop_p     = 1'b0;
        pre_p      = 1'b0;
        clr_p      = 1'b0;
        cur_p      = 1'b0;
        advance_ok = i_item.ready_req && !i_item.warn_active;

        if (i_item.error_active || !i_item.start_req) begin
            // forced stop, no chain
            if (p != ccs_pkg::PH_STOP || e) begin
                stop_p = 1'b1;
                fan    = 1'b0;
                brk    = 1'b0;
            end
            p = ccs_pkg::PH_STOP;
            e = 1'b0;
        end else begin
            if (p == ccs_pkg::PH_STOP) begin
                if (e) begin
                    stop_p = 1'b1;
                    fan    = 1'b0;
                    brk    = 1'b0;
                    e      = 1'b0;
                end
                if (advance_ok) begin
                    p = ccs_pkg::PH_PRE;
                    e = 1'b1;
                end
            end

            if (p == ccs_pkg::PH_PRE) begin
                if (e) begin
                    pre_p = 1'b1;
                    e     = 1'b0;
                end
                if (!i_item.ready_req) begin
                    // drop back and run stop entry; ready stays low so it ends there
                    p      = ccs_pkg::PH_STOP;
                    stop_p = 1'b1;
                    fan    = 1'b0;
                    brk    = 1'b0;
                    e      = 1'b0;
                end else begin
                    fan = 1'b1;
                    if (i_item.precharge_done && !i_item.warn_active) begin
                        p = ccs_pkg::PH_BRK;
                        e = 1'b1;
                    end
                end
            end

            if (p == ccs_pkg::PH_BRK) begin
                if (e) begin
                    cnt   = '0;
                    clr_p = 1'b1;
                    e     = 1'b0;
                end else if (i_item.tick && (cnt != {COUNT_BITS{1'b1}})) begin
                    cnt = cnt + 1'b1;
                end
                if (CMP_W'(cnt) >= CMP_W'(i_settle_delay)) begin
                    brk = 1'b1;
                    p   = ccs_pkg::PH_WORK;
                    e   = 1'b1;
                end
            end

            if (p == ccs_pkg::PH_WORK) begin
                e     = 1'b0;
                cur_p = 1'b1;
            end
        end
    end

    always_comb begin
        o_state.phase         = p;
        o_state.entry_pending = e;
        o_state.fan_level     = fan;
        o_state.breaker_level = brk;
        o_count               = cnt;

        o_result.phase              = p;
        o_result.working            = (p == ccs_pkg::PH_WORK);
        o_result.stop_entry         = stop_p;
        o_result.fan_on             = fan;
        o_result.battery_breaker_on = brk;
        o_result.precharge_restart  = pre_p;
        o_result.fault_clear        = clr_p;
        o_result.current_update     = cur_p;
    end

endmodule

[rtl/charger_contactor_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charger_contactor_sequencer: four-phase charge sequencer
//
// Channels: i_item carries one evaluation (ready, start, warning, error,
// precharge done, tick); o_result returns one result transaction per item
// (phase, working, entry pulses, fan and breaker levels). i_cfg writes the
// settle delay in ticks; it is always ready, and the user must write it
// only while idle; the block itself does not enforce this. An accepted
// item lands in the input register, is evaluated and registered in the
// result register, and its result is offered from there.
// Throughput: one item per cycle while the receiver keeps ready high; the
// whole phase chain resolves in the evaluation logic between the registers.
// Reset: phase stop with the stop entry pending, settle count cleared,
// fan and breaker off, settle delay 1000, both registers empty.
// Stall: while the receiver holds ready low the result holds, the input
// register still takes one more item, then ready to the sender drops.
// ----------------------------------------------------------------------------
module charger_contactor_sequencer #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ccs_stream_if.sink   i_item,
    ccs_stream_if.source o_result,
    ccs_stream_if.sink   i_cfg
);

    logic                          r_in_valid;
    ccs_pkg::t_in_item             r_in;
    logic                          r_out_valid;
    ccs_pkg::t_out_item            r_out;
    ccs_pkg::t_seq_state           r_state;
    logic [COUNT_BITS-1:0]         r_count;
    logic [ccs_pkg::DELAY_W-1:0]   r_settle_delay;

    ccs_pkg::t_seq_state           n_state;
    logic [COUNT_BITS-1:0]         n_count;
    ccs_pkg::t_out_item            n_out;
    logic                          adv;

    // move the held item into the result register
    assign adv = r_in_valid && (!r_out_valid || o_result.ready);

    assign i_item.ready   = !r_in_valid || adv;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    ccs_eval #(
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .i_state        (r_state),
        .i_count        (r_count),
        .i_item         (r_in),
        .i_settle_delay (r_settle_delay),
        .o_state        (n_state),
        .o_count        (n_count),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state.phase          <= ccs_pkg::PH_STOP;
            r_state.entry_pending  <= 1'b1;
            r_state.fan_level      <= 1'b0;
            r_state.breaker_level  <= 1'b0;
            r_count                <= '0;
            r_settle_delay         <= ccs_pkg::SETTLE_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_settle_delay <= i_cfg.data.settle_delay;
            end
            if (i_item.valid && i_item.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_count     <= n_count;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state) && $stable(r_count))
        else $error("sequencer state changed without a transaction");

    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (o_result.data.phase == r_state.phase) && o_result.valid)
        else $error("result phase differs from stored phase");

    a_breaker_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.breaker_level == (r_state.phase == ccs_pkg::PH_WORK))
        else $error("breaker level out of step with work phase");

    a_pending_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.entry_pending |-> (r_state.phase == ccs_pkg::PH_STOP))
        else $error("entry left pending outside stop phase");
`endif

endmodule

[verif/tb_charger_contactor_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_charger_contactor_sequencer: self-checking bench of the charge sequencer
// A short directed table (reset behavior, forced stop, warning hold, zero and
// nonzero settle delays) and then randomized evaluations are driven over the
// item channel. Every accepted item runs through a phase predictor in the
// bench, and each result transaction is compared field by field in order.
// Random idle gaps on both sides, one long receiver hold-off and repeated full
// drains cover the handshake under back-pressure.
// ----------------------------------------------------------------------------
module tb_charger_contactor_sequencer;

    localparam int CNT_BITS     = 16;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_WAIT  = 4;
    localparam int N_PHASES     = 7;
    localparam int PHASE_ITEMS  = 108;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        ccs_pkg::t_in_item  item;
        logic [15:0]        delay;
        bit                 typed;
        ccs_pkg::t_out_item result;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;

    ccs_stream_if #(.t_payload(ccs_pkg::t_in_item))  item_if ();
    ccs_stream_if #(.t_payload(ccs_pkg::t_out_item)) res_if ();
    ccs_stream_if #(.t_payload(ccs_pkg::t_cfg_item)) cfg_if ();

    charger_contactor_sequencer #(.COUNT_BITS(CNT_BITS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // sequencer state mirrored by the bench
    ccs_pkg::t_phase                seq_phase;
    logic                           seq_pending;
    logic [CNT_BITS-1:0]            settle_cnt;
    logic                           fan_lvl;
    logic                           brk_lvl;
    logic [ccs_pkg::DELAY_W-1:0]    settle_delay_q;

    ccs_pkg::t_out_item  pending_results[$];
    t_step_row           dir_tab[$];
    int                  err_cnt;
    bit                  quiet;
    bit                  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Evaluate one item: apply forced stop, then settle the phase chain.
    function automatic ccs_pkg::t_out_item eval_sequencer(input ccs_pkg::t_in_item it);
        ccs_pkg::t_out_item r;
        ccs_pkg::t_phase    p;
        logic      e;
        logic      fin;
        logic      stop_p;
        logic      pre_p;
        logic      clr_p;
        logic      cur_p;
        int        i;
        p = seq_phase;
        e = seq_pending;
        fin = 1'b0;
        stop_p = 1'b0;
        pre_p = 1'b0;
        clr_p = 1'b0;
        cur_p = 1'b0;
        if (it.error_active || !it.start_req) begin
            if (p != ccs_pkg::PH_STOP || e) begin
                stop_p = 1'b1;
                fan_lvl = 1'b0;
                brk_lvl = 1'b0;
            end
            p = ccs_pkg::PH_STOP;
            e = 1'b0;
            fin = 1'b1;
        end
        for (i = 0; i < 8 && !fin; i++) begin
            case (p)
                ccs_pkg::PH_STOP: begin
                    if (e) begin
                        stop_p = 1'b1;
                        fan_lvl = 1'b0;
                        brk_lvl = 1'b0;
                        e = 1'b0;
                    end
                    if (it.ready_req && !it.warn_active) begin
                        p = ccs_pkg::PH_PRE;
                        e = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                ccs_pkg::PH_PRE: begin
                    if (e) begin
                        pre_p = 1'b1;
                        e = 1'b0;
                    end
                    if (!it.ready_req) begin
                        p = ccs_pkg::PH_STOP;
                        e = 1'b1;
                    end else begin
                        fan_lvl = 1'b1;
                        if (it.precharge_done && !it.warn_active) begin
                            p = ccs_pkg::PH_BRK;
                            e = 1'b1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
                ccs_pkg::PH_BRK: begin
                    // no tick counts in the item that enters the phase
                    if (e) begin
                        settle_cnt = '0;
                        clr_p = 1'b1;
                        e = 1'b0;
                    end else if (it.tick && settle_cnt < CNT_MAX) begin
                        settle_cnt = settle_cnt + 1'b1;
                    end
                    if (settle_cnt >= settle_delay_q) begin
                        brk_lvl = 1'b1;
                        p = ccs_pkg::PH_WORK;
                        e = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    e = 1'b0;
                    cur_p = 1'b1;
                    fin = 1'b1;
                end
            endcase
        end
        seq_phase = p;
        seq_pending = e;
        r.phase = p;
        r.working = (p == ccs_pkg::PH_WORK);
        r.stop_entry = stop_p;
        r.fan_on = fan_lvl;
        r.battery_breaker_on = brk_lvl;
        r.precharge_restart = pre_p;
        r.fault_clear = clr_p;
        r.current_update = cur_p;
        return r;
    endfunction

    function automatic ccs_pkg::t_in_item rand_item();
        ccs_pkg::t_in_item it;
        if ($urandom_range(0, 4) == 0) begin
            it = ccs_pkg::t_in_item'(6'($urandom_range(0, 63)));
        end else begin
            it.ready_req = ($urandom_range(0, 19) != 0);
            it.start_req = ($urandom_range(0, 29) != 0);
            it.warn_active = ($urandom_range(0, 9) == 0);
            it.error_active = ($urandom_range(0, 29) == 0);
            it.precharge_done = ($urandom_range(0, 2) == 0);
            it.tick = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    function automatic t_step_row item_row(input logic [5:0] bits, input bit typed = 1'b0,
                                           input logic [8:0] res_bits = '0);
        t_step_row row;
        row.kind = ROW_ITEM;
        row.item = ccs_pkg::t_in_item'(bits);
        row.delay = '0;
        row.typed = typed;
        row.result = ccs_pkg::t_out_item'(res_bits);
        return row;
    endfunction

    function automatic t_step_row cfg_row(input logic [15:0] value);
        t_step_row row;
        row = item_row(6'b0);
        row.kind = ROW_CFG;
        row.delay = value;
        return row;
    endfunction

    task automatic cmp_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    task automatic check_result(input ccs_pkg::t_out_item got);
        ccs_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %b", $time, got);
            err_cnt++;
        end else begin
            want = pending_results.pop_front();
            cmp_field("phase", want.phase, got.phase);
            cmp_field("working", want.working, got.working);
            cmp_field("stop_entry", want.stop_entry, got.stop_entry);
            cmp_field("fan_on", want.fan_on, got.fan_on);
            cmp_field("battery_breaker_on", want.battery_breaker_on, got.battery_breaker_on);
            cmp_field("precharge_restart", want.precharge_restart, got.precharge_restart);
            cmp_field("fault_clear", want.fault_clear, got.fault_clear);
            cmp_field("current_update", want.current_update, got.current_update);
        end
    endtask

    // Hold valid high across back-to-back transactions; drop it only for a gap.
    task automatic send_item(input ccs_pkg::t_in_item it, input bit typed = 1'b0,
                             input ccs_pkg::t_out_item typed_res = '0);
        int                 gap;
        ccs_pkg::t_out_item res;
        gap = draw_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data <= it;
        do @(posedge i_clk); while (!item_if.ready);
        res = eval_sequencer(it);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_settle_delay(input logic [15:0] value);
        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        settle_delay_q = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) check_result(res_if.data);
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                stall = HOLD_CYCLES;
                rx_hold = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    initial begin
        logic [15:0] phase_delay [N_PHASES];
        int          ph;
        int          n;
        err_cnt = 0;
        quiet = 1'b0;
        rx_hold = 1'b0;
        seq_phase = ccs_pkg::PH_STOP;
        seq_pending = 1'b1;
        settle_cnt = '0;
        fan_lvl = 1'b0;
        brk_lvl = 1'b0;
        settle_delay_q = ccs_pkg::SETTLE_RESET;
        phase_delay = '{16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd4, 16'd2};
        phase_delay[4] = 16'($urandom_range(0, 15));

        // columns: ready start warn error pdone tick
        // result:  phase working stop fan brk pre clr cur
        dir_tab.push_back(item_row(6'b000000, 1'b1, 9'b00_0_1_0_0_0_0_0)); // stop entry after reset
        dir_tab.push_back(item_row(6'b000000, 1'b1, 9'b00_0_0_0_0_0_0_0));
        dir_tab.push_back(item_row(6'b110100, 1'b1, 9'b00_0_0_0_0_0_0_0)); // error cancels advance
        dir_tab.push_back(item_row(6'b111000, 1'b1, 9'b00_0_0_0_0_0_0_0)); // warning holds stop
        dir_tab.push_back(item_row(6'b110000));
        dir_tab.push_back(item_row(6'b010000));
        dir_tab.push_back(item_row(6'b110010));
        dir_tab.push_back(item_row(6'b110001));
        dir_tab.push_back(item_row(6'b110100));
        dir_tab.push_back(cfg_row(16'd0));
        dir_tab.push_back(item_row(6'b110010)); // zero delay: straight through to work
        dir_tab.push_back(item_row(6'b110000));
        dir_tab.push_back(item_row(6'b111011));
        dir_tab.push_back(item_row(6'b101011));
        dir_tab.push_back(cfg_row(16'd2));
        dir_tab.push_back(item_row(6'b110011));
        dir_tab.push_back(item_row(6'b110010));
        dir_tab.push_back(item_row(6'b110001));
        dir_tab.push_back(item_row(6'b110001));
        dir_tab.push_back(item_row(6'b111111, 1'b1, 9'b00_0_1_0_0_0_0_0));
        dir_tab.push_back(cfg_row(16'hFFFF));
        dir_tab.push_back(item_row(6'b111011, 1'b1, 9'b00_0_0_0_0_0_0_0));
        dir_tab.push_back(item_row(6'b110010));
        dir_tab.push_back(item_row(6'b110001));
        dir_tab.push_back(item_row(6'b100000));

        i_rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) write_settle_delay(dir_tab[k].delay);
            else send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].result);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_settle_delay(phase_delay[ph]);
            quiet = (ph == 2 || ph == 5);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 20) rx_hold = 1'b1;
                if (ph == 3 && n == 50) drain_results();
                send_item(rand_item());
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
